### hdl/smmd_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and tables of the slot memory mapper decoder.
package smmd_pkg;

	localparam int SEGMENTS      = 8;
	localparam int SEGMENT_BYTES = 16384;
	localparam int OFF_W         = 14;
	localparam int SEG_W         = (SEGMENTS > 1) ? $clog2(SEGMENTS) : 1;
	localparam int RAM_AW        = SEG_W + OFF_W;
	localparam int RAM_DEPTH     = SEGMENTS * SEGMENT_BYTES;

	localparam logic [15:0] SSR_ADDR   = 16'hFFFF;
	localparam logic [13:0] FDC_A_LO   = 14'h3FF8;
	localparam logic [13:0] FDC_A_HI   = 14'h3FFF;
	localparam logic [13:0] FDC_B_LO   = 14'h3FB8;
	localparam logic [13:0] FDC_B_HI   = 14'h3FBC;
	localparam logic [7:0]  BYTE_NONE  = 8'hFF;

	localparam logic [1:0] SLOT_BIOS  = 2'd0;
	localparam logic [1:0] SLOT_CART  = 2'd1;
	localparam logic [1:0] SLOT_EXP   = 2'd3;
	localparam logic [1:0] SUB_SUBROM = 2'd0;
	localparam logic [1:0] SUB_RAM    = 2'd1;
	localparam logic [1:0] SUB_DISK   = 2'd2;
	localparam logic [1:0] PAGE_0     = 2'd0;
	localparam logic [1:0] PAGE_1     = 2'd1;
	localparam logic [1:0] PAGE_2     = 2'd2;

	localparam logic CFG_SLOT3_EXP = 1'b0;
	localparam logic CFG_LOGO      = 1'b1;

	typedef enum logic [2:0] {
		OP_MEM_RD = 3'd0,
		OP_MEM_WR = 3'd1,
		OP_SEG_RD = 3'd2,
		OP_SEG_WR = 3'd3,
		OP_PSL_WR = 3'd4
	} op_t;

	typedef enum logic [3:0] {
		TGT_UNMAPPED = 4'd0,
		TGT_BIOS     = 4'd1,
		TGT_LOGO     = 4'd2,
		TGT_CART     = 4'd3,
		TGT_SUBROM   = 4'd4,
		TGT_RAM      = 4'd5,
		TGT_DISKROM  = 4'd6,
		TGT_FDC      = 4'd7,
		TGT_REG      = 4'd8
	} tgt_t;

	typedef enum logic [1:0] {
		RAM_NONE = 2'd0,
		RAM_RD   = 2'd1,
		RAM_WR   = 2'd2
	} ram_op_t;

	typedef struct packed {
		tgt_t               target;
		logic [14:0]        offset;
		logic [7:0]         rdata;
		ram_op_t            ram_op;
		logic [RAM_AW-1:0]  ram_addr;
		logic [7:0]         wdata;
	} cmd_t;

	typedef struct packed {
		logic slot3_expanded;
		logic logo_present;
	} cfg_t;

	typedef logic [SEG_W-1:0] seg_idx_t;
	typedef seg_idx_t seg_tbl_t [256];

	function automatic seg_tbl_t seg_tbl_f();
		seg_tbl_t t;
		for (int i = 0; i < 256; i++) begin
			t[i] = SEG_W'(i % SEGMENTS);
		end
		return t;
	endfunction

	localparam seg_tbl_t SEG_MOD_TBL = seg_tbl_f();

endpackage

### hdl/smmd_front.sv
`timescale 1ns / 1ps
// Front end: slot and segment registers, access classification.
module smmd_front (
	input  logic              clk,
	input  logic              arst_n,
	input  smmd_pkg::cfg_t    cfg,
	input  logic              accept,
	input  logic [2:0]        opcode,
	input  logic [15:0]       address,
	input  logic [7:0]        wdata,
	output smmd_pkg::cmd_t    cmd
);
	import smmd_pkg::*;

	logic [7:0]  psr_q;
	logic [7:0]  ssr_q;
	logic [7:0]  seg_q [4];
	seg_idx_t    segm_q [4];

	logic [1:0]  page;
	logic [13:0] off;
	logic [1:0]  prim;
	logic [1:0]  sub;
	logic        is_exp;
	logic        fdc_win;
	logic        ssr_hit;
	logic [1:0]  rsel;

	assign page    = address[15:14];
	assign off     = address[13:0];
	assign rsel    = address[1:0];
	assign prim    = psr_q[{page, 1'b0} +: 2];
	assign is_exp  = (prim == SLOT_EXP) && cfg.slot3_expanded;
	assign sub     = is_exp ? ssr_q[{page, 1'b0} +: 2] : SUB_SUBROM;
	assign fdc_win = off inside {[FDC_A_LO:FDC_A_HI], [FDC_B_LO:FDC_B_HI]};
	assign ssr_hit = (address == SSR_ADDR) && is_exp;

	always_comb begin
		cmd.target   = TGT_UNMAPPED;
		cmd.offset   = '0;
		cmd.rdata    = BYTE_NONE;
		cmd.ram_op   = RAM_NONE;
		cmd.ram_addr = {segm_q[page], off};
		cmd.wdata    = wdata;
		case (op_t'(opcode))
			OP_MEM_RD, OP_MEM_WR: begin
				if (ssr_hit) begin
					cmd.target = TGT_REG;
					if (op_t'(opcode) == OP_MEM_RD) begin
						cmd.rdata = ~ssr_q;
					end
				end else if (is_exp && sub == SUB_DISK && fdc_win) begin
					cmd.target = TGT_FDC;
					cmd.offset = {1'b0, off};
				end else if (prim == SLOT_BIOS) begin
					if (page == PAGE_0 || page == PAGE_1) begin
						cmd.target = TGT_BIOS;
						cmd.offset = {page[0], off};
					end else if (page == PAGE_2 && cfg.logo_present) begin
						cmd.target = TGT_LOGO;
						cmd.offset = {1'b0, off};
					end
				end else if (prim == SLOT_CART) begin
					cmd.target = TGT_CART;
					cmd.offset = {1'b0, off};
				end else if (prim == SLOT_EXP) begin
					if (sub == SUB_SUBROM && page == PAGE_0) begin
						cmd.target = TGT_SUBROM;
						cmd.offset = {1'b0, off};
					end else if (sub == SUB_RAM) begin
						cmd.target = TGT_RAM;
						cmd.offset = {1'b0, off};
						cmd.ram_op = (op_t'(opcode) == OP_MEM_WR) ? RAM_WR : RAM_RD;
					end else if (sub == SUB_DISK && page == PAGE_1) begin
						cmd.target = TGT_DISKROM;
						cmd.offset = {1'b0, off};
					end
				end
			end
			OP_SEG_RD: begin
				cmd.target = TGT_REG;
				cmd.offset = {13'd0, rsel};
				cmd.rdata  = seg_q[rsel];
			end
			OP_SEG_WR: begin
				cmd.target = TGT_REG;
				cmd.offset = {13'd0, rsel};
			end
			OP_PSL_WR: begin
				cmd.target = TGT_REG;
			end
			default: begin
				cmd.target = TGT_UNMAPPED;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			psr_q     <= '0;
			ssr_q     <= '0;
			seg_q[0]  <= 8'd3;
			seg_q[1]  <= 8'd2;
			seg_q[2]  <= 8'd1;
			seg_q[3]  <= 8'd0;
			segm_q[0] <= SEG_MOD_TBL[3];
			segm_q[1] <= SEG_MOD_TBL[2];
			segm_q[2] <= SEG_MOD_TBL[1];
			segm_q[3] <= SEG_MOD_TBL[0];
		end else if (accept) begin
			case (op_t'(opcode))
				OP_MEM_WR: begin
					if (ssr_hit) begin
						ssr_q <= wdata;
					end
				end
				OP_SEG_WR: begin
					seg_q[rsel]  <= wdata;
					segm_q[rsel] <= SEG_MOD_TBL[wdata];
				end
				OP_PSL_WR: begin
					psr_q <= wdata;
				end
				default: begin
				end
			endcase
		end
	end

endmodule

### hdl/smmd_queue.sv
`timescale 1ns / 1ps
// Two-entry command queue between the front end and the back end.
module smmd_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  smmd_pkg::cmd_t push_cmd,
	output logic           full,
	output logic           q_valid,
	input  logic           pop,
	output smmd_pkg::cmd_t pop_cmd
);
	import smmd_pkg::*;

	cmd_t       slot_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;

	assign full    = (cnt_q == 2'd2);
	assign q_valid = (cnt_q != 2'd0);
	assign pop_cmd = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

### hdl/smmd_back.sv
`timescale 1ns / 1ps
// Back end: paged RAM with clearing pass, result output register.
module smmd_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           q_valid,
	input  smmd_pkg::cmd_t cmd,
	output logic           pop,
	output logic           clr_busy,
	output logic           out_valid,
	input  logic           out_stall,
	output logic [3:0]     target,
	output logic [14:0]    offset,
	output logic [7:0]     rdata
);
	import smmd_pkg::*;

	logic [7:0]        mem [RAM_DEPTH];
	logic [7:0]        ram_rd_q;
	logic              clr_busy_q;
	logic [RAM_AW-1:0] clr_addr_q;
	logic              valid_q;
	tgt_t              target_q;
	logic [14:0]       offset_q;
	logic [7:0]        rdata_q;
	logic              use_ram_q;
	logic              mem_we;
	logic [RAM_AW-1:0] mem_wa;
	logic [7:0]        mem_wd;

	assign clr_busy  = clr_busy_q;
	assign pop       = q_valid && !clr_busy_q && (!valid_q || !out_stall);
	assign out_valid = valid_q;
	assign target    = target_q;
	assign offset    = offset_q;
	assign rdata     = use_ram_q ? ram_rd_q : rdata_q;

	assign mem_we = clr_busy_q || (pop && cmd.ram_op == RAM_WR);
	assign mem_wa = clr_busy_q ? clr_addr_q : cmd.ram_addr;
	assign mem_wd = clr_busy_q ? 8'd0 : cmd.wdata;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
		if (pop && cmd.ram_op == RAM_RD) begin
			ram_rd_q <= mem[cmd.ram_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			target_q  <= cmd.target;
			offset_q  <= cmd.offset;
			rdata_q   <= cmd.rdata;
			use_ram_q <= (cmd.ram_op == RAM_RD);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_addr_q <= '0;
			valid_q    <= 1'b0;
		end else begin
			if (clr_busy_q) begin
				clr_addr_q <= clr_addr_q + RAM_AW'(1);
				if (clr_addr_q == RAM_AW'(RAM_DEPTH - 1)) begin
					clr_busy_q <= 1'b0;
				end
			end
			if (pop) begin
				valid_q <= 1'b1;
			end else if (!out_stall) begin
				valid_q <= 1'b0;
			end
		end
	end

endmodule

### hdl/slot_memory_mapper_decode.sv
`timescale 1ns / 1ps
// Top level of the slot memory mapper decoder.
// Usage:
//   Input channel (in_valid, in_stall, opcode, address, wdata) takes one CPU
//   bus transaction: memory read/write, segment register read/write or
//   primary slot write. Output channel (out_valid, out_stall, target, offset,
//   rdata) returns one classified result per transaction, in order.
//   APB port: register 0 slot3_expanded at 0x0, register 1 logo_present at 0x4.
// Timing:
//   The front end classifies and updates slot/segment registers at the
//   accepting edge and pushes into a two-entry queue; the back end then takes
//   the queue head into the output register, where the result is shown.
//   Throughput is one transaction per cycle while out_stall is low and the
//   RAM clear is done.
// Reset:
//   After reset the 131072-byte RAM is cleared one byte per cycle; in_stall
//   stays high until the clear is done. APB writes are taken throughout.
// Stall:
//   While out_stall is high the result holds; the queue fills and in_stall
//   rises once two further transactions wait.
module slot_memory_mapper_decode (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [2:0]  opcode,
	input  logic [15:0] address,
	input  logic [7:0]  wdata,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [3:0]  target,
	output logic [14:0] offset,
	output logic [7:0]  rdata
);
	import smmd_pkg::*;

	cfg_t cfg_q;
	cmd_t front_cmd;
	cmd_t back_cmd;
	logic accept;
	logic q_full;
	logic q_valid;
	logic pop;
	logic clr_busy;

	assign pready   = 1'b1;
	assign in_stall = clr_busy || q_full;
	assign accept   = in_valid && !in_stall;
	assign prdata   = (paddr[2] == CFG_SLOT3_EXP) ? {31'd0, cfg_q.slot3_expanded}
	                                              : {31'd0, cfg_q.logo_present};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.slot3_expanded <= 1'b1;
			cfg_q.logo_present   <= 1'b0;
		end else if (psel && penable && pwrite && pready) begin
			if (paddr[2] == CFG_SLOT3_EXP) begin
				cfg_q.slot3_expanded <= pwdata[0];
			end
			if (paddr[2] == CFG_LOGO) begin
				cfg_q.logo_present <= pwdata[0];
			end
		end
	end

	smmd_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_q),
		.accept  (accept),
		.opcode  (opcode),
		.address (address),
		.wdata   (wdata),
		.cmd     (front_cmd)
	);

	smmd_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (accept),
		.push_cmd (front_cmd),
		.full     (q_full),
		.q_valid  (q_valid),
		.pop      (pop),
		.pop_cmd  (back_cmd)
	);

	smmd_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.cmd       (back_cmd),
		.pop       (pop),
		.clr_busy  (clr_busy),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.target    (target),
		.offset    (offset),
		.rdata     (rdata)
	);

endmodule

### hdl/smmd_checker.sv
`timescale 1ns / 1ps
// Port-level checker for the slot memory mapper decoder, with its bind.
module smmd_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_stall,
	input logic [3:0]  target,
	input logic [14:0] offset,
	input logic [7:0]  rdata
);
	import smmd_pkg::*;

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result dropped while stalled");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(target) && $stable(offset) && $stable(rdata))
		else $error("stalled result changed");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && target != TGT_RAM && target != TGT_REG |-> rdata == BYTE_NONE)
		else $error("non-data target returned data");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && target == TGT_UNMAPPED |-> offset == 15'd0)
		else $error("unmapped result with nonzero offset");

endmodule

bind slot_memory_mapper_decode smmd_checker u_smmd_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.target    (target),
	.offset    (offset),
	.rdata     (rdata)
);

### sim/slot_decode_checker.sv
`timescale 1ns / 1ps
// Checker for the slot memory mapper decoder: predicts and compares each result.
module slot_decode_checker
	import smmd_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic        pready,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	input  logic        in_valid,
	input  logic        in_stall,
	input  logic [2:0]  opcode,
	input  logic [15:0] address,
	input  logic [7:0]  wdata,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic [3:0]  target,
	input  logic [14:0] offset,
	input  logic [7:0]  rdata,
	output int          fails,
	output int          pending
);

	typedef struct packed {
		tgt_t        target;
		logic [14:0] offset;
		logic [7:0]  rdata;
	} bus_result_t;

	cfg_t        cfg_now;
	logic [7:0]  psl_img;
	logic [7:0]  ssl_img;
	logic [7:0]  seg_img [4];
	logic [7:0]  ram_img [RAM_DEPTH];
	bus_result_t decode_due [$];

	initial begin
		cfg_now.slot3_expanded = 1'b1;
		cfg_now.logo_present = 1'b0;
		psl_img = '0;
		ssl_img = '0;
		seg_img[0] = 8'd3;
		seg_img[1] = 8'd2;
		seg_img[2] = 8'd1;
		seg_img[3] = 8'd0;
		for (int i = 0; i < RAM_DEPTH; i++) begin
			ram_img[i] = '0;
		end
		fails = 0;
		pending = 0;
	end

	task automatic decode_bus_txn(input logic [2:0] op, input logic [15:0] addr,
			input logic [7:0] wd, output bus_result_t res);
		logic [1:0]  page;
		logic [1:0]  prim;
		logic [1:0]  sub;
		logic [13:0] off;
		logic        is_wr;
		logic        in_fdc;
		int unsigned idx;
		res.target = TGT_UNMAPPED;
		res.offset = '0;
		res.rdata = BYTE_NONE;
		page = addr[15:14];
		off = addr[13:0];
		prim = psl_img[page*2 +: 2];
		sub = (prim == SLOT_EXP && cfg_now.slot3_expanded) ? ssl_img[page*2 +: 2] : 2'b00;
		in_fdc = (off >= FDC_A_LO && off <= FDC_A_HI) || (off >= FDC_B_LO && off <= FDC_B_HI);
		idx = (int'(seg_img[page]) % SEGMENTS) * SEGMENT_BYTES + int'(off);
		case (op)
			OP_MEM_RD, OP_MEM_WR: begin
				is_wr = (op == OP_MEM_WR);
				if (addr == SSR_ADDR && prim == SLOT_EXP && cfg_now.slot3_expanded) begin
					res.target = TGT_REG;
					if (is_wr) ssl_img = wd;
					else res.rdata = ~ssl_img;
				end else if (prim == SLOT_EXP && sub == SUB_DISK && cfg_now.slot3_expanded
						&& in_fdc) begin
					res.target = TGT_FDC;
					res.offset = {1'b0, off};
				end else if (prim == SLOT_BIOS) begin
					if (page <= PAGE_1) begin
						res.target = TGT_BIOS;
						res.offset = {page[0], off};
					end else if (page == PAGE_2 && cfg_now.logo_present) begin
						res.target = TGT_LOGO;
						res.offset = {1'b0, off};
					end
				end else if (prim == SLOT_CART) begin
					res.target = TGT_CART;
					res.offset = {1'b0, off};
				end else if (prim == SLOT_EXP) begin
					if (sub == SUB_SUBROM && page == PAGE_0) begin
						res.target = TGT_SUBROM;
						res.offset = {1'b0, off};
					end else if (sub == SUB_RAM) begin
						res.target = TGT_RAM;
						res.offset = {1'b0, off};
						if (is_wr) ram_img[idx] = wd;
						else res.rdata = ram_img[idx];
					end else if (sub == SUB_DISK && page == PAGE_1) begin
						res.target = TGT_DISKROM;
						res.offset = {1'b0, off};
					end
				end
			end
			OP_SEG_RD: begin
				res.target = TGT_REG;
				res.offset = 15'(addr[1:0]);
				res.rdata = seg_img[addr[1:0]];
			end
			OP_SEG_WR: begin
				seg_img[addr[1:0]] = wd;
				res.target = TGT_REG;
				res.offset = 15'(addr[1:0]);
			end
			OP_PSL_WR: begin
				psl_img = wd;
				res.target = TGT_REG;
			end
			default: ;
		endcase
	endtask

	always @(posedge clk) begin
		bus_result_t want;
		bus_result_t fresh;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (decode_due.size() == 0) begin
					if (fails < 10)
						$display("checker: result with none due: target %0d offset %h rdata %h",
							target, offset, rdata);
					fails++;
				end else begin
					want = decode_due.pop_front();
					if (target !== want.target || offset !== want.offset
							|| rdata !== want.rdata) begin
						if (fails < 10)
							$display({"checker: mismatch: expected target %0d offset %h rdata %h,",
								" got target %0d offset %h rdata %h"},
								want.target, want.offset, want.rdata, target, offset, rdata);
						fails++;
					end
				end
			end
			if (in_valid && !in_stall) begin
				decode_bus_txn(opcode, address, wdata, fresh);
				decode_due = {decode_due, fresh};
			end
			if (psel && penable && pwrite && pready) begin
				if (paddr[2] == CFG_LOGO) cfg_now.logo_present = pwdata[0];
				else cfg_now.slot3_expanded = pwdata[0];
			end
			pending = decode_due.size();
		end
	end

endmodule

### sim/tb_top.sv
`timescale 1ns / 1ps
// Testbench top for the slot memory mapper decoder: clock, reset, stimulus and verdict.
module tb_top;
	import smmd_pkg::*;

	logic        clk;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;
	logic        in_valid;
	logic        in_stall;
	logic [2:0]  opcode;
	logic [15:0] address;
	logic [7:0]  wdata;
	logic        out_valid;
	logic        out_stall;
	logic [3:0]  target;
	logic [14:0] offset;
	logic [7:0]  rdata;

	int          chk_fails;
	int          chk_pending;
	int          src_idle_pct = 0;
	int          snk_stall_pct = 0;
	logic        hold_go;
	logic [15:0] hot_addr [8];

	slot_memory_mapper_decode dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.opcode   (opcode),
		.address  (address),
		.wdata    (wdata),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.target   (target),
		.offset   (offset),
		.rdata    (rdata)
	);

	slot_decode_checker checker_i (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.pready   (pready),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.opcode   (opcode),
		.address  (address),
		.wdata    (wdata),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.target   (target),
		.offset   (offset),
		.rdata    (rdata),
		.fails    (chk_fails),
		.pending  (chk_pending)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#(40_000_000);
		$display("tb_top: done, errors");
		$finish;
	end

	initial begin : receiver
		int   hold_left;
		logic go_seen;
		hold_left = 0;
		go_seen = 1'b0;
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_go != go_seen) begin
				go_seen = hold_go;
				hold_left = 80;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= ($urandom_range(99, 0) < snk_stall_pct);
			end
		end
	end

	task automatic send_txn(input logic [2:0] op, input logic [15:0] addr, input logic [7:0] wd);
		while ($urandom_range(99, 0) < src_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		opcode <= op;
		address <= addr;
		wdata <= wd;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (chk_pending != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic apb_write(input logic reg_sel, input logic [31:0] value);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {reg_sel, 2'b00};
		pwdata <= value;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	function automatic logic [15:0] pick_address();
		logic [15:0] a;
		int          r;
		r = $urandom_range(99, 0);
		if (r < 40) a = hot_addr[$urandom_range(7, 0)];
		else if (r < 48) a = {2'($urandom_range(3, 0)), 14'h3FB0 + 14'($urandom_range(15, 0))};
		else if (r < 56) a = {2'($urandom_range(3, 0)), 14'h3FF0 + 14'($urandom_range(15, 0))};
		else a = 16'($urandom());
		if ($urandom_range(9, 0) == 0) hot_addr[$urandom_range(7, 0)] = a;
		return a;
	endfunction

	task automatic random_txn();
		logic [2:0]  op;
		logic [15:0] a;
		logic [7:0]  wd;
		int          r;
		r = $urandom_range(99, 0);
		a = pick_address();
		wd = 8'($urandom());
		if (r < 38) begin
			op = OP_MEM_RD;
		end else if (r < 62) begin
			op = OP_MEM_WR;
		end else if (r < 68) begin
			op = OP_SEG_RD;
		end else if (r < 76) begin
			op = OP_SEG_WR;
		end else if (r < 84) begin
			op = OP_PSL_WR;
			if ($urandom_range(1, 0)) wd[7:6] = SLOT_EXP;
		end else if (r < 92) begin
			op = OP_MEM_WR;
			a = SSR_ADDR;
		end else if (r < 97) begin
			op = OP_MEM_RD;
			a = SSR_ADDR;
		end else begin
			op = 3'($urandom_range(7, int'(OP_PSL_WR) + 1));
		end
		send_txn(op, a, wd);
	endtask

	initial begin : stimulus
		logic cfg_exp;
		logic cfg_logo;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		in_valid = 1'b0;
		opcode = OP_MEM_RD;
		address = '0;
		wdata = '0;
		hold_go = 1'b0;
		for (int i = 0; i < 8; i++) begin
			hot_addr[i] = 16'($urandom());
		end
		repeat (11) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		send_txn(OP_MEM_RD, 16'h0000, 8'h00);
		send_txn(OP_MEM_RD, 16'h7FFF, 8'hFF);
		send_txn(OP_MEM_RD, 16'h8000, 8'h00);
		send_txn(OP_MEM_WR, 16'h4000, 8'hA5);
		send_txn(OP_SEG_RD, 16'h0000, 8'h00);
		send_txn(OP_SEG_RD, 16'hFFFF, 8'h00);
		send_txn(OP_SEG_WR, 16'h0002, 8'hFF);
		send_txn(OP_PSL_WR, 16'h0000, 8'hFF);
		send_txn(OP_MEM_RD, SSR_ADDR, 8'h00);
		send_txn(OP_MEM_WR, SSR_ADDR, 8'h96);
		send_txn(OP_MEM_RD, SSR_ADDR, 8'h00);
		send_txn(OP_MEM_RD, 16'h3FF8, 8'h00);
		send_txn(OP_MEM_RD, 16'h3FBC, 8'h00);
		send_txn(OP_MEM_RD, 16'h3FBD, 8'h00);
		send_txn(OP_MEM_RD, 16'h3FB7, 8'h00);
		send_txn(OP_MEM_WR, 16'h4000, 8'h5A);
		send_txn(OP_MEM_RD, 16'h4000, 8'h00);
		send_txn(OP_MEM_WR, 16'hBFFF, 8'hC3);
		send_txn(OP_MEM_RD, 16'hBFFF, 8'h00);
		send_txn(OP_MEM_RD, 16'hFFFE, 8'h00);
		send_txn(OP_MEM_WR, SSR_ADDR, 8'h00);
		send_txn(OP_MEM_RD, 16'h0000, 8'h00);
		send_txn(3'($urandom_range(7, int'(OP_PSL_WR) + 1)), 16'hFFFF, 8'hFF);
		send_txn(OP_PSL_WR, 16'h0000, 8'h55);
		send_txn(OP_MEM_RD, 16'hC000, 8'h00);

		for (int c = 0; c < 4; c++) begin
			drain();
			cfg_exp = (c >= 2);
			cfg_logo = (c == 1 || c == 2);
			apb_write(CFG_SLOT3_EXP, 32'(cfg_exp));
			apb_write(CFG_LOGO, 32'(cfg_logo));
			@(negedge clk);
			for (int m = 0; m < 4; m++) begin
				case (m)
					0: begin
						src_idle_pct = 0;
						snk_stall_pct <= 0;
					end
					1: begin
						src_idle_pct = 46;
						snk_stall_pct <= 0;
					end
					2: begin
						src_idle_pct = 0;
						snk_stall_pct <= 46;
					end
					default: begin
						src_idle_pct = 30;
						snk_stall_pct <= 30;
					end
				endcase
				for (int n = 0; n < 95; n++) begin
					if (m == 0 && n == 30) hold_go <= ~hold_go;
					if (m == 1 && n == 50) drain();
					random_txn();
				end
			end
		end

		drain();
		if (chk_fails == 0 && chk_pending == 0) begin
			$display("tb_top: done, clean");
		end else begin
			$display("tb_top: done, errors");
		end
		$finish;
	end

endmodule

### sim.f
hdl/smmd_pkg.sv
hdl/smmd_front.sv
hdl/smmd_queue.sv
hdl/smmd_back.sv
hdl/slot_memory_mapper_decode.sv
hdl/smmd_checker.sv
sim/slot_decode_checker.sv
sim/tb_top.sv
